// ===== hw/rtl/iedf_pkg.sv =====
// Shared types, codes and the fixed-length band table of the escape deframer.
`default_nettype none
package iedf_pkg;

  // Result kinds as they appear on the output channel.
  localparam logic [1:0] KIND_PLAIN   = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_EMPTY   = 2'd2;
  localparam logic [1:0] KIND_ERROR   = 2'd3;

  // Reset value of the escape byte register.
  localparam logic [7:0] ESC_RESET = 8'd251;

  // One result item as it travels from the front through the queue to the back.
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [7:0] msg_type;
    logic       last;
  } iedf_item_t;

  // Queue occupancy seen by the front.
  typedef struct packed {
    logic full;
    logic empty;
  } iedf_qstat_t;

  // Payload length of a fixed-length message, chosen by the type's band of sixteen.
  function automatic logic [15:0] fixed_length(input logic [6:0] t);
    logic [15:0] len;
    case (t[6:4])
      3'd0:    len = 16'd4;
      3'd1:    len = 16'd16;
      3'd2:    len = 16'd64;
      3'd3:    len = 16'd128;
      3'd4:    len = 16'd512;
      3'd5:    len = 16'd1024;
      3'd6:    len = 16'd2048;
      default: len = 16'd4196;
    endcase
    return len;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/iedf_front.sv =====
// Front end: accepts raw bytes, tracks escape framing and produces result items.
`default_nettype none
module iedf_front (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  cfg_we,
  input  wire  [7:0]           cfg_wdata,
  input  wire                  byte_valid,
  input  wire  [7:0]           byte_in,
  input  wire iedf_pkg::iedf_qstat_t qstat,
  output logic                 byte_ready,
  output logic                 push,
  output iedf_pkg::iedf_item_t push_item
);
  import iedf_pkg::*;

  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_ESC     = 3'd1;
  localparam logic [2:0] PH_LEN_HI  = 3'd2;
  localparam logic [2:0] PH_LEN_LO  = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;

  logic [2:0]  phase_r, phase_nxt;
  logic [15:0] left_r, left_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [7:0]  len_hi_r, len_hi_nxt;
  logic        halted_r, halted_nxt;
  logic [7:0]  esc_r;
  logic        accept;
  logic [15:0] left_dec;
  logic [15:0] chan_len;

  // A byte is taken whenever the queue has room; results never wait inside the front.
  assign byte_ready = ~qstat.full;
  assign accept     = byte_valid & byte_ready;
  assign left_dec   = left_r - {15'd0, (left_r != 16'd0)};
  assign chan_len   = {len_hi_r, byte_in};

  // Escape byte register; a write applies from the next byte on.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_r <= ESC_RESET;
    end else if (cfg_we) begin
      esc_r <= cfg_wdata;
    end
  end

  // Framing state machine, one byte per cycle while the queue has room.
  always_comb begin
    phase_nxt  = phase_r;
    left_nxt   = left_r;
    type_nxt   = type_r;
    len_hi_nxt = len_hi_r;
    halted_nxt = halted_r;
    push       = 1'b0;
    push_item  = '{kind: KIND_PLAIN, data: byte_in, msg_type: 8'd0, last: 1'b0};
    if (accept && !halted_r) begin
      case (phase_r)
        PH_ESC: begin
          if (byte_in == esc_r) begin
            // Doubled escape passes one literal escape byte.
            phase_nxt = PH_IDLE;
            push      = 1'b1;
          end else if (byte_in == 8'd0) begin
            // A zero type is fatal: report once and stop.
            type_nxt   = 8'd0;
            halted_nxt = 1'b1;
            phase_nxt  = PH_IDLE;
            push       = 1'b1;
            push_item  = '{kind: KIND_ERROR, data: 8'd0, msg_type: 8'd0, last: 1'b0};
          end else begin
            type_nxt = byte_in;
            if (byte_in[7]) begin
              phase_nxt = PH_LEN_HI;
            end else begin
              left_nxt  = fixed_length(byte_in[6:0]);
              phase_nxt = PH_PAYLOAD;
            end
          end
        end
        PH_LEN_HI: begin
          len_hi_nxt = byte_in;
          phase_nxt  = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          left_nxt = chan_len;
          if (chan_len == 16'd0) begin
            phase_nxt = PH_IDLE;
            push      = 1'b1;
            push_item = '{kind: KIND_EMPTY, data: 8'd0, msg_type: type_r, last: 1'b1};
          end else begin
            phase_nxt = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          // Payload bytes are passed as they are, escape bytes included.
          left_nxt  = left_dec;
          push      = 1'b1;
          push_item = '{kind: KIND_PAYLOAD, data: byte_in, msg_type: type_r,
                        last: (left_dec == 16'd0)};
          if (left_dec == 16'd0) begin
            phase_nxt = PH_IDLE;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
          if (byte_in == esc_r) begin
            type_nxt  = 8'd0;
            phase_nxt = PH_ESC;
          end else begin
            push = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      left_r   <= 16'd0;
      type_r   <= 8'd0;
      len_hi_r <= 8'd0;
      halted_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      left_r   <= left_nxt;
      type_r   <= type_nxt;
      len_hi_r <= len_hi_nxt;
      halted_r <= halted_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/iedf_queue.sv =====
// Short result queue that decouples the front end from the output stage.
`default_nettype none
module iedf_queue #(
  parameter int DEPTH = 2
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   push,
  input  wire iedf_pkg::iedf_item_t push_item,
  input  wire                   pop,
  output iedf_pkg::iedf_item_t  pop_item,
  output iedf_pkg::iedf_qstat_t qstat
);
  import iedf_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  iedf_item_t   slot_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push;
  logic          do_pop;

  assign qstat.full  = (count_r == CW'(DEPTH));
  assign qstat.empty = (count_r == '0);
  assign do_push     = push & ~qstat.full;
  assign do_pop      = pop & ~qstat.empty;
  assign pop_item    = slot_r[rd_ptr_r];

  // Pointer and occupancy bookkeeping.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage slots hold whole result items: kind, data, message type and last flag.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/iedf_back.sv =====
// Output stage: holds one result beat and formats it for the output channel.
`default_nettype none
module iedf_back (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  q_empty,
  input  wire iedf_pkg::iedf_item_t q_item,
  output logic                 q_pop,
  input  wire                  out_tready,
  output logic                 out_tvalid,
  output logic [23:0]          out_tdata,
  output logic [2:0]           out_tuser,
  output logic                 out_tlast
);
  import iedf_pkg::*;

  logic       valid_r, valid_nxt;
  iedf_item_t item_r;

  // Refill the stage when it is empty or its beat leaves this cycle.
  assign q_pop = ~q_empty & (~valid_r | out_tready);

  always_comb begin
    valid_nxt = valid_r;
    if (q_pop) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      item_r <= q_item;
    end
  end

  // Message number and channel flag are split from the raw type byte.
  assign out_tvalid = valid_r;
  assign out_tdata  = {1'b0, item_r.msg_type[6:0], item_r.msg_type, item_r.data};
  assign out_tuser  = {item_r.msg_type[7], item_r.kind};
  assign out_tlast  = item_r.last;

endmodule
`default_nettype wire

// ===== hw/rtl/inband_escape_deframer_unit.sv =====
// Top level of the in-band escape deframer: front end, result queue and output stage.
//
// The block takes one received byte per beat and sorts plain bytes from escape-framed
// messages. It accepts a byte in every cycle as long as the result queue has room, and
// its front end frames it in the cycle it is accepted; the result passes through a queue
// slot and the output register, so a continuous stream runs at one byte per cycle unless
// the output stalls. Escape opening, nonzero type and high length bytes give no output
// beat; a zero channel length gives one empty-message beat. After a zero type byte one
// error beat is sent and every later byte is taken and dropped until reset. The escape
// byte register resets to 251 and is to be written only while no message is in flight.
`default_nettype none
module inband_escape_deframer_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire         clk,
  input  wire         rst_n,
  // Escape byte register write.
  input  wire         cfg_we,
  input  wire  [7:0]  cfg_wdata,
  // Input beats.
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,    // [7:0] in_byte
  // Result beats.
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [23:0] out_tdata,   // [7:0] out_byte, [15:8] msg_type, [22:16] msg_number
  output logic [2:0]  out_tuser,   // [1:0] out_kind, [2] is_channel
  output logic        out_tlast    // is_last
);
  import iedf_pkg::*;

  logic        push;
  iedf_item_t  push_item;
  iedf_item_t  pop_item;
  iedf_qstat_t qstat;
  logic        pop;

  iedf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .byte_valid(in_tvalid),
    .byte_in   (in_tdata),
    .qstat     (qstat),
    .byte_ready(in_tready),
    .push      (push),
    .push_item (push_item)
  );

  iedf_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_item(push_item),
    .pop      (pop),
    .pop_item (pop_item),
    .qstat    (qstat)
  );

  iedf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (qstat.empty),
    .q_item    (pop_item),
    .q_pop     (pop),
    .out_tready(out_tready),
    .out_tvalid(out_tvalid),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  // Plain bytes carry no message tag and never close a message.
  a_plain_untagged: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1:0] == KIND_PLAIN |-> !out_tlast && out_tdata[23:8] == 16'd0
    && !out_tuser[2])
    else $error("plain byte beat carries a message tag");

  // An empty-message beat closes a channel message and has no data byte.
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1:0] == KIND_EMPTY |-> out_tlast && out_tuser[2]
    && out_tdata[7:0] == 8'd0)
    else $error("empty message beat is malformed");

  // The error beat is all zeros apart from its kind.
  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1:0] == KIND_ERROR |-> !out_tlast && out_tdata == 24'd0
    && !out_tuser[2])
    else $error("protocol error beat is not cleared");

  // A full queue must hold off the input side.
  a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    qstat.full |-> !in_tready)
    else $error("input taken while the result queue is full");

endmodule
`default_nettype wire

// ===== sim/inband_escape_deframer_unit_test.sv =====
// Self-checking testbench for the in-band escape deframer unit.
module inband_escape_deframer_unit_test;
  import iedf_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int DRAIN_LIMIT   = 20_000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 120;
  localparam int MAX_REPORTS   = 40;
  localparam int PHASE_BYTES   = 130;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ESC,
    ST_LEN_HI,
    ST_LEN_LO,
    ST_PAYLOAD
  } frame_state_t;

  // One result beat as the predictor expects it.
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [7:0] msg_type;
    logic [6:0] msg_number;
    logic       channel;
    logic       last;
  } deframed_beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [7:0]  cfg_wdata = 8'h00;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;

  // Stream bytes waiting to be sent and results waiting to arrive.
  logic [7:0]     pending_bytes[$];
  deframed_beat_t expected_beats[$];

  // Predictor state, advanced at every accepted input beat.
  frame_state_t fr_state = ST_IDLE;
  logic [15:0]  fr_remain = 16'h0000;
  logic [7:0]   fr_type = 8'h00;
  logic [7:0]   fr_len_hi = 8'h00;
  logic         fr_halted = 1'b0;
  logic [7:0]   esc_value = ESC_RESET;

  // Escape value the stimulus is built around.
  logic [7:0] gen_esc = ESC_RESET;

  int gap_max = 0;
  int stall_max = 0;
  int gap_left = 0;
  int stall_left = 0;
  int hold_left = 0;
  logic hold_start = 1'b0;
  int phase_bytes = 0;
  int mismatches = 0;
  int results_seen = 0;
  int cycle_count = 0;

  inband_escape_deframer_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Payload length of a fixed-length message type.
  function automatic logic [15:0] band_length(input logic [6:0] t);
    if (t < 7'd16) return 16'd4;
    if (t < 7'd32) return 16'd16;
    if (t < 7'd48) return 16'd64;
    if (t < 7'd64) return 16'd128;
    if (t < 7'd80) return 16'd512;
    if (t < 7'd96) return 16'd1024;
    if (t < 7'd112) return 16'd2048;
    return 16'd4196;
  endfunction

  task automatic expect_beat(input logic [1:0] kind, input logic [7:0] data,
                             input logic with_tag, input logic last);
    deframed_beat_t b;
    b.kind       = kind;
    b.data       = data;
    b.msg_type   = with_tag ? fr_type : 8'h00;
    b.msg_number = with_tag ? fr_type[6:0] : 7'h00;
    b.channel    = with_tag ? fr_type[7] : 1'b0;
    b.last       = last;
    expected_beats.push_back(b);
  endtask

  // Advances the framing state by one received byte and queues its result, if any.
  task automatic deframe_byte(input logic [7:0] b);
    logic [15:0] n;
    if (fr_halted) return;
    case (fr_state)
      ST_ESC: begin
        if (b == esc_value) begin
          fr_state = ST_IDLE;
          expect_beat(KIND_PLAIN, b, 1'b0, 1'b0);
        end else if (b == 8'h00) begin
          fr_type   = 8'h00;
          fr_halted = 1'b1;
          fr_state  = ST_IDLE;
          expect_beat(KIND_ERROR, 8'h00, 1'b0, 1'b0);
        end else begin
          fr_type = b;
          if (b[7]) begin
            fr_state = ST_LEN_HI;
          end else begin
            fr_remain = band_length(b[6:0]);
            fr_state  = ST_PAYLOAD;
          end
        end
      end
      ST_LEN_HI: begin
        fr_len_hi = b;
        fr_state  = ST_LEN_LO;
      end
      ST_LEN_LO: begin
        n = {fr_len_hi, b};
        fr_remain = n;
        if (n == 16'h0000) begin
          fr_state = ST_IDLE;
          expect_beat(KIND_EMPTY, 8'h00, 1'b1, 1'b1);
        end else begin
          fr_state = ST_PAYLOAD;
        end
      end
      ST_PAYLOAD: begin
        if (fr_remain != 16'h0000) fr_remain = fr_remain - 16'd1;
        if (fr_remain == 16'h0000) begin
          fr_state = ST_IDLE;
          expect_beat(KIND_PAYLOAD, b, 1'b1, 1'b1);
        end else begin
          expect_beat(KIND_PAYLOAD, b, 1'b1, 1'b0);
        end
      end
      default: begin
        fr_state = ST_IDLE;
        if (b == esc_value) begin
          fr_type  = 8'h00;
          fr_state = ST_ESC;
        end else begin
          expect_beat(KIND_PLAIN, b, 1'b0, 1'b0);
        end
      end
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("mismatch at result %0d: %s got %0h expected %0h", results_seen, what, got,
               want);
    end
  endtask

  // Compares the beat on the output with the oldest expectation.
  task automatic check_beat();
    deframed_beat_t want;
    results_seen++;
    if (expected_beats.size() == 0) begin
      report_mismatch("unexpected beat, kind", 16'(out_tuser[1:0]), 16'h0);
      return;
    end
    want = expected_beats.pop_front();
    if (out_tuser[1:0] !== want.kind) begin
      report_mismatch("out_kind", 16'(out_tuser[1:0]), 16'(want.kind));
    end
    if (out_tdata[7:0] !== want.data) begin
      report_mismatch("out_byte", 16'(out_tdata[7:0]), 16'(want.data));
    end
    if (out_tdata[15:8] !== want.msg_type) begin
      report_mismatch("msg_type", 16'(out_tdata[15:8]), 16'(want.msg_type));
    end
    if (out_tdata[22:16] !== want.msg_number) begin
      report_mismatch("msg_number", 16'(out_tdata[22:16]), 16'(want.msg_number));
    end
    if (out_tuser[2] !== want.channel) begin
      report_mismatch("is_channel", 16'(out_tuser[2]), 16'(want.channel));
    end
    if (out_tlast !== want.last) begin
      report_mismatch("is_last", 16'(out_tlast), 16'(want.last));
    end
  endtask

  // Input driver: one byte per beat, with a random gap after each one.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      gap_left  <= 0;
      fr_state  = ST_IDLE;
      fr_remain = 16'h0000;
      fr_type   = 8'h00;
      fr_len_hi = 8'h00;
      fr_halted = 1'b0;
      esc_value = ESC_RESET;
    end else begin
      if (in_tvalid && in_tready) deframe_byte(in_tdata);
      if (cfg_we) esc_value = cfg_wdata;
      if (!in_tvalid || in_tready) begin
        if (gap_left != 0) begin
          in_tvalid <= 1'b0;
          gap_left  <= gap_left - 1;
        end else if (pending_bytes.size() != 0) begin
          in_tdata  <= pending_bytes.pop_front();
          in_tvalid <= 1'b1;
          gap_left  <= $urandom_range(0, gap_max);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each beat and stalls at random after it.
  always @(posedge clk) begin : result_monitor
    int wait_n;
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left <= 0;
    end else begin
      wait_n = stall_left;
      if (out_tvalid && out_tready) begin
        check_beat();
        wait_n = $urandom_range(0, stall_max);
      end
      if (wait_n != 0) begin
        out_tready <= 1'b0;
        stall_left <= wait_n - 1;
      end else begin
        out_tready <= (hold_left == 0);
        stall_left <= 0;
      end
    end
  end

  // Long receiver hold-off, counted here so the sender keeps going meanwhile.
  always @(posedge clk) begin
    if (hold_start) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Watchdog on the whole run.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("inband_escape_deframer_unit_test: FAIL");
    $finish;
  end

  // Random byte for payloads, biased toward the escape value and the extremes.
  function automatic logic [7:0] content_byte();
    case ($urandom_range(0, 7))
      0: return gen_esc;
      1: return 8'h00;
      2: return 8'hFF;
      default: return 8'($urandom());
    endcase
  endfunction

  // Random byte that never opens an escape.
  function automatic logic [7:0] noise_byte();
    logic [7:0] v;
    v = 8'($urandom());
    if (v == gen_esc) v = ~v;
    return v;
  endfunction

  // Nonzero type byte that differs from the escape value.
  function automatic logic [7:0] pick_type(input logic channel);
    logic [7:0] t;
    do begin
      if (channel) begin
        t = 8'($urandom_range(128, 255));
      end else begin
        case ($urandom_range(0, 19))
          0, 1: t = 8'($urandom_range(16, 31));
          2: t = 8'($urandom_range(32, 47));
          default: t = 8'($urandom_range(1, 15));
        endcase
      end
    end while (t == gen_esc);
    return t;
  endfunction

  task automatic push_byte(input logic [7:0] b);
    pending_bytes.push_back(b);
    phase_bytes++;
  endtask

  task automatic send_fixed(input logic [7:0] t);
    push_byte(gen_esc);
    push_byte(t);
    repeat (band_length(t[6:0])) push_byte(content_byte());
  endtask

  task automatic send_channel(input logic [7:0] t, input logic [15:0] n);
    push_byte(gen_esc);
    push_byte(t);
    push_byte(n[15:8]);
    push_byte(n[7:0]);
    repeat (n) push_byte(content_byte());
  endtask

  task automatic wait_sender_idle();
    @(negedge clk);
    while (pending_bytes.size() != 0 || in_tvalid) @(negedge clk);
  endtask

  // Feeds filler bytes until the framing state is back outside any message.
  task automatic resync_frame();
    logic [7:0] fill;
    fill = (gen_esc == 8'h01) ? 8'h02 : 8'h01;
    wait_sender_idle();
    while (!fr_halted && fr_state != ST_IDLE) begin
      case (fr_state)
        ST_LEN_HI: push_byte(8'h00);
        ST_PAYLOAD: repeat (fr_remain) push_byte(fill);
        default: push_byte(fill);
      endcase
      wait_sender_idle();
    end
  endtask

  // A message cut short or run on, followed by a resync.
  task automatic send_broken();
    logic [7:0] t;
    t = pick_type(1'($urandom_range(0, 1)));
    push_byte(gen_esc);
    push_byte(t);
    if (t[7]) push_byte(8'h00);
    repeat ($urandom_range(0, 6)) push_byte(noise_byte());
    resync_frame();
  endtask

  task automatic send_random_sequence();
    int pick;
    int n;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      send_fixed(pick_type(1'b0));
    end else if (pick < 60) begin
      case ($urandom_range(0, 19))
        0, 1: n = 0;
        2: n = $urandom_range(13, 300);
        default: n = $urandom_range(1, 12);
      endcase
      send_channel(pick_type(1'b1), 16'(n));
    end else if (pick < 70) begin
      push_byte(gen_esc);
      push_byte(gen_esc);
    end else if (pick < 85) begin
      repeat ($urandom_range(1, 6)) push_byte(noise_byte());
    end else begin
      send_broken();
    end
  endtask

  // Waits until the block is idle with nothing left to deliver.
  task automatic settle_phase();
    resync_frame();
    while (expected_beats.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_escape(input logic [7:0] v);
    gen_esc = v;
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic start_hold();
    @(posedge clk);
    hold_start <= 1'b1;
    @(posedge clk);
    hold_start <= 1'b0;
    @(negedge clk);
  endtask

  initial begin : stimulus
    logic [7:0] esc_plan[6];
    int         gap_plan[6];
    int         stall_plan[6];
    int         drain;

    esc_plan   = '{8'h00, 8'hFF, 8'h1B, 8'($urandom()), ESC_RESET, 8'($urandom())};
    gap_plan   = '{8, 0, 8, 0, 4, 8};
    stall_plan = '{8, 0, 0, 8, 4, 8};

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part with the escape byte at its reset value.
    gap_max   = 2;
    stall_max = 2;
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(gen_esc);
    push_byte(gen_esc);
    push_byte(gen_esc);
    push_byte(8'h01);
    push_byte(gen_esc);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(8'h5A);
    send_channel(8'h80, 16'h0000);
    send_channel(8'hFF, 16'h0002);
    push_byte(gen_esc);
    push_byte(8'h0F);
    repeat (4) push_byte(content_byte());
    settle_phase();

    // The shorter length bands and a two-byte channel length, at full rate.
    gap_max   = 0;
    stall_max = 0;
    send_fixed(8'h10);
    send_fixed(8'h2F);
    send_fixed(8'h30);
    send_channel(8'hC3, 16'h0100);
    settle_phase();

    // Random phases, each under its own escape value and idling pattern.
    for (int p = 0; p < 6; p++) begin
      gap_max   = gap_plan[p];
      stall_max = stall_plan[p];
      write_escape(esc_plan[p]);
      if (p == 1) start_hold();
      phase_bytes = 0;
      while (phase_bytes < PHASE_BYTES) send_random_sequence();
      settle_phase();
    end

    // A zero type byte halts the block; everything after it is dropped.
    gap_max   = 3;
    stall_max = 3;
    push_byte(gen_esc);
    push_byte(8'h00);
    repeat (20) push_byte(content_byte());
    wait_sender_idle();

    drain = 0;
    while (expected_beats.size() != 0 && drain < DRAIN_LIMIT) begin
      @(negedge clk);
      drain++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (expected_beats.size() != 0) begin
      report_mismatch("results never delivered", 16'(expected_beats.size()), 16'h0);
    end

    if (mismatches == 0) begin
      $display("inband_escape_deframer_unit_test: PASS");
    end else begin
      $display("inband_escape_deframer_unit_test: FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/iedf_pkg.sv
hw/rtl/iedf_front.sv
hw/rtl/iedf_queue.sv
hw/rtl/iedf_back.sv
hw/rtl/inband_escape_deframer_unit.sv
sim/inband_escape_deframer_unit_test.sv
